// ===== hdl/ritoa_pkg.sv =====
// Package for the radix integer-to-ASCII converter.
// Holds the fixed field widths, radix limits and the digit-to-ASCII mapping.
// No dependencies.
`timescale 1ns / 1ps

package ritoa_pkg;

	localparam int unsigned RADIX_W = 6;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned IN_W    = 64;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

	// Maps a remainder (0 to 35) to its lower-case ASCII digit.
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 6'd10) begin
			c = CHAR_ZERO + {1'b0, d};
		end else begin
			c = CHAR_LOWER_A + {1'b0, d} - 7'd10;
		end
		return c;
	endfunction

endpackage

// ===== hdl/radix_integer_to_ascii.sv =====
// Each digit comes from a full pass of bit-serial division over the value;
// the converter works on one item at a time, set by the single shared
// one-bit-per-cycle divider.
// Reset: arst_n asynchronously clears the state machine and the output valid.
//
// Top level of the radix integer-to-ASCII converter.
// Depends on ritoa_pkg for widths, radix limits and the digit mapping.
`timescale 1ns / 1ps

module radix_integer_to_ascii #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ritoa_pkg::IN_W-1:0]    value,
	input  logic [ritoa_pkg::RADIX_W-1:0] radix,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ritoa_pkg::CHAR_W-1:0]  digit_char,
	output logic                          last_digit,
	output logic                          empty_res
);
	import ritoa_pkg::*;

	// The digit stack holds one remainder per digit; at most VALUE_WIDTH digits
	// arise, at radix 2.
	localparam int unsigned AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_READ  = 5'b00100,
		S_LOAD  = 5'b01000,
		S_EMPTY = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [VALUE_WIDTH-1:0]   val_q;
	logic [RADIX_W-1:0]       radix_q;
	logic [RADIX_W-1:0]       rem_q;
	logic [AW-1:0]            bit_q;
	logic [AW-1:0]            wp_q;
	logic [AW-1:0]            ptr_q;
	logic [RADIX_W-1:0]       rd_q;
	logic [RADIX_W-1:0]       stack_q [VALUE_WIDTH];

	logic                     out_valid_q;
	logic [CHAR_W-1:0]        digit_char_q;
	logic                     last_digit_q;
	logic                     empty_res_q;

	logic                     accept;
	logic                     radix_ok;
	logic [RADIX_W:0]         trial;
	logic                     fits;
	logic [RADIX_W-1:0]       rem_nx;
	logic [VALUE_WIDTH-1:0]   val_nx;
	logic                     digit_done;
	logic                     stack_we;
	logic                     out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
	assign out_free = !out_valid_q || out_ready;

	// One restoring-division step: shift the next value bit into the partial
	// remainder and subtract the radix when it fits. The quotient bit shifts
	// into the bottom of the value register, so after VALUE_WIDTH steps the
	// register holds the quotient and the last step's rem_nx is the remainder.
	always_comb begin
		trial  = {rem_q, val_q[VALUE_WIDTH-1]};
		fits   = trial >= {1'b0, radix_q};
		rem_nx = fits ? RADIX_W'(trial - {1'b0, radix_q}) : trial[RADIX_W-1:0];
		val_nx = {val_q[VALUE_WIDTH-2:0], fits};
	end

	assign digit_done = (state_q == S_DIV) && (bit_q == AW'(VALUE_WIDTH - 1));
	assign stack_we   = digit_done;

	// Digit stack: remainders are pushed least significant first and popped in
	// reverse, which gives the most significant digit first.
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_q[wp_q] <= rem_nx;
		end
		rd_q <= stack_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= radix_ok ? S_DIV : S_EMPTY;
					end
				end
				S_DIV: begin
					if (digit_done && (val_nx == '0)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= (ptr_q == '0) ? S_IDLE : S_READ;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the divider and the stack pointers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				val_q   <= value[VALUE_WIDTH-1:0];
				radix_q <= radix;
				rem_q   <= '0;
				bit_q   <= '0;
				wp_q    <= '0;
			end
			S_DIV: begin
				val_q <= val_nx;
				if (digit_done) begin
					rem_q <= '0;
					bit_q <= '0;
					if (val_nx != '0) begin
						wp_q <= wp_q + 1'b1;
					end else begin
						ptr_q <= wp_q;
					end
				end else begin
					rem_q <= rem_nx;
					bit_q <= bit_q + 1'b1;
				end
			end
			S_LOAD: begin
				if (out_free && (ptr_q != '0)) begin
					ptr_q <= ptr_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: a finished word waits here while the next digit is read or the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == S_LOAD) || (state_q == S_EMPTY)) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_LOAD) && out_free) begin
			digit_char_q <= digit_ascii(rd_q);
			last_digit_q <= (ptr_q == '0);
			empty_res_q  <= 1'b0;
		end else if ((state_q == S_EMPTY) && out_free) begin
			digit_char_q <= '0;
			last_digit_q <= 1'b1;
			empty_res_q  <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last_digit = last_digit_q;
	assign empty_res  = empty_res_q;

endmodule

// ===== hdl/ritoa_checker.sv =====
// Port-level checker for the radix integer-to-ASCII converter, with its bind.
// Depends on ritoa_pkg for the field widths.
`timescale 1ns / 1ps

module ritoa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ritoa_pkg::CHAR_W-1:0]  digit_char,
	input logic                          last_digit,
	input logic                          empty_res
);
	import ritoa_pkg::*;

	// A stalled word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char)
			&& $stable(last_digit) && $stable(empty_res))
		else $error("output word changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// The empty result is a single final word with a zero character.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last_digit && (digit_char == '0))
		else $error("malformed empty result");

	// Every digit is a lower-case ASCII digit or letter.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_res |->
			((digit_char >= 7'h30) && (digit_char <= 7'h39))
			|| ((digit_char >= 7'h61) && (digit_char <= 7'h7a)))
		else $error("digit outside 0-9 and a-z");

endmodule

bind radix_integer_to_ascii ritoa_checker u_ritoa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digit_char (digit_char),
	.last_digit (last_digit),
	.empty_res  (empty_res)
);
